// ----- design/adist_pkg.sv -----
package adist_pkg;

  // Sample and register widths
  localparam int SAMP_W     = 16;
  localparam int MIX_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SAT_W      = 34;

  // Pipeline stage map (0 is loaded at the input handshake, the last is the output word)
  localparam int NUM_STG  = 11;
  localparam int STG_GAIN = 1;
  localparam int STG_SQ   = 2;
  localparam int STG_SG   = 3;
  localparam int STG_QQ   = 4;
  localparam int STG_WS   = 5;
  localparam int STG_DIVQ = 7;
  localparam int STG_WET  = 8;
  localparam int STG_MIX  = 9;
  localparam int STG_OUT  = 10;

  // Waveshaper divider: one setup stage, then three quotient bits per stage
  localparam int DIV_STG   = STG_DIVQ - STG_SQ + 1;
  localparam int DIV_STEPS = 3;
  localparam int DIV_Q_W   = 15;
  localparam int DIV_D_W   = 17;

  localparam logic [DIV_D_W-1:0] Q15_ONE = 17'd32768;

  // floor(t / 3) = (t * 43691) >> 17 for any t below 2^17
  localparam logic [15:0] RECIP3    = 16'd43691;
  localparam int          RECIP3_SH = 17;

  localparam logic signed [SAT_W-1:0] SAT_HI = 34'sd32767;
  localparam logic signed [SAT_W-1:0] SAT_LO = -34'sd32768;

  typedef enum logic [1:0] {
    MODE_SOFT = 2'd0,
    MODE_HARD = 2'd1,
    MODE_WAVE = 2'd2,
    MODE_RAW  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 2'd0,
    REG_MODE     = 2'd1,
    REG_PRE_GAIN = 2'd2,
    REG_WET_MIX  = 2'd3
  } reg_idx_t;

  // Clamp to the signed 16-bit range
  function automatic logic signed [SAMP_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [SAMP_W-1:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7fff;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/audio_distortion_q15.sv -----
// Q15 audio distortion: one 16-bit sample in, one sample out, no state between samples.
// Input channel: in_valid / in_stall / in_sample_in; a word is taken on a rising edge
// with in_valid high and in_stall low. Output channel: out_valid / out_stall /
// out_sample_out, same rule. Configuration: cfg_valid / cfg_ready (always ready) with
// cfg_index 0 enable, 1 mode, 2 pre_gain, 3 wet_mix and data on cfg_wdata; only the low
// bits of each register are kept. Write registers only while the pipeline is empty.
// A result is presented once its sample has passed 11 register stages, the last being the
// output register. Throughput: one sample per clock while out_stall is low; the
// waveshaper divide runs over five stages at three quotient bits each, alongside the
// soft-clip multiplies.
// Stall: each stage holds while the stage after it is full and held, so out_stall backs
// up through the pipe; empty stages keep filling, and in_stall rises only when every
// stage holds a word. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous): pipeline emptied, enable 0, mode waveshaper,
// pre_gain 32767, wet_mix 16384.
module audio_distortion_q15 (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [adist_pkg::SAMP_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [adist_pkg::SAMP_W-1:0]  out_sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adist_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adist_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import adist_pkg::*;

  // Configuration registers
  logic                     enable_r;
  mode_t                    mode_r;
  logic signed [SAMP_W-1:0] pre_gain_r;
  logic [MIX_W-1:0]         wet_mix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      mode_r     <= MODE_WAVE;
      pre_gain_r <= 16'sh7fff;
      wet_mix_r  <= 15'd16384;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:   enable_r   <= cfg_wdata[0];
        REG_MODE:     mode_r     <= mode_t'(cfg_wdata[1:0]);
        REG_PRE_GAIN: pre_gain_r <= $signed(cfg_wdata[SAMP_W-1:0]);
        REG_WET_MIX:  wet_mix_r  <= cfg_wdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and load enables: a stage loads when empty or when its successor moves
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] stg_en;

  always_comb begin
    stg_en[NUM_STG-1] = !vld_r[NUM_STG-1] || !out_stall;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NUM_STG; k++) begin
        if (stg_en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_stall  = !stg_en[0];
  assign out_valid = vld_r[NUM_STG-1];

  // Dry sample and gained sample travel alongside the math
  logic signed [SAMP_W-1:0] x_r [0:STG_OUT-1];
  logic signed [SAMP_W-1:0] g_r [STG_GAIN:STG_DIVQ];

  // Stage datapath registers
  logic signed [31:0]       prod_r;
  logic [SAMP_W-1:0]        sq_hi_r;
  logic signed [31:0]       sg_r;
  logic [31:0]              qq_r;
  logic                     neg_r;
  logic signed [16:0]       ws_r [STG_WS:STG_DIVQ];
  logic signed [16:0]       wet_r;
  logic signed [32:0]       wm_r;
  logic signed [32:0]       dm_r;
  logic signed [SAMP_W-1:0] out_r;

  // Combinational terms between stages
  logic signed [31:0]       gain_sq;
  logic signed [32:0]       sg_full;
  logic                     sg_neg;
  logic [30:0]              sg_mag;
  logic signed [16:0]       g_ext;
  logic signed [16:0]       q3_s;
  logic signed [16:0]       soft_wet;
  logic [SAMP_W-1:0]        g_mag;
  logic [DIV_Q_W-1:0]       div_q;
  logic signed [16:0]       div_s;
  logic signed [16:0]       wave_wet;
  logic signed [16:0]       hard_wet;
  logic signed [16:0]       raw_wet;
  logic signed [16:0]       wet_sel;
  logic [SAMP_W-1:0]        dry_gain;
  logic signed [16:0]       mix_s;
  logic signed [16:0]       dry_s;
  logic signed [32:0]       wm_full;
  logic signed [32:0]       dm_full;
  logic signed [SAMP_W-1:0] wet_sat;
  logic signed [SAMP_W-1:0] dry_sat;
  logic signed [16:0]       wet_ext;
  logic signed [16:0]       dry_ext;
  logic signed [16:0]       mix_sum;
  logic signed [SAMP_W-1:0] mixed;

  // Soft clip: (g*g)>>15 times g, then magnitude divided by 98304 = 3 << 15
  always_comb begin
    gain_sq  = 32'(g_r[STG_GAIN]) * 32'(g_r[STG_GAIN]);
    sg_full  = 33'($signed({1'b0, sq_hi_r})) * 33'(g_r[STG_SQ]);
    sg_neg   = sg_r[31];
    sg_mag   = sg_neg ? 31'(-sg_r) : sg_r[30:0];
    g_ext    = 17'(g_r[STG_QQ]);
    q3_s     = $signed({2'b00, qq_r[31:RECIP3_SH]});
    soft_wet = g_ext - (neg_r ? -q3_s : q3_s);
  end

  // Waveshaper: divider works on |g|, sign restored at the end
  assign g_mag = g_r[STG_GAIN][SAMP_W-1] ? 16'(-g_r[STG_GAIN]) : 16'(g_r[STG_GAIN]);

  adist_div u_div (
    .clk     (clk),
    .stg_en  (stg_en[STG_DIVQ:STG_SQ]),
    .mag_in  (g_mag),
    .quo_out (div_q)
  );

  // Shaper select
  always_comb begin
    div_s    = $signed({2'b00, div_q});
    wave_wet = g_r[STG_DIVQ][SAMP_W-1] ? -div_s : div_s;
    hard_wet = 17'(g_r[STG_DIVQ]);
    raw_wet  = 17'(x_r[STG_DIVQ]);
    case (mode_r)
      MODE_SOFT: wet_sel = ws_r[STG_DIVQ];
      MODE_HARD: wet_sel = hard_wet;
      MODE_WAVE: wet_sel = wave_wet;
      MODE_RAW:  wet_sel = raw_wet;
      default:   wet_sel = raw_wet;
    endcase
  end

  // Wet/dry gains; dry gain of 32768 stays exact unity
  always_comb begin
    dry_gain = 16'(Q15_ONE - {2'b00, wet_mix_r});
    mix_s    = $signed({2'b00, wet_mix_r});
    dry_s    = $signed({1'b0, dry_gain});
    wm_full  = 33'(wet_r) * 33'(mix_s);
    dm_full  = 33'(x_r[STG_WET]) * 33'(dry_s);
  end

  // Final saturating mix
  always_comb begin
    wet_sat = sat16(34'(wm_r >>> 15));
    dry_sat = sat16(34'(dm_r >>> 15));
    wet_ext = 17'(wet_sat);
    dry_ext = 17'(dry_sat);
    mix_sum = wet_ext + dry_ext;
    mixed   = sat16(34'(mix_sum));
  end

  // Datapath registers, each held while its stage is stalled
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      x_r[0] <= in_sample_in;
      prod_r <= 32'(in_sample_in) * 32'(pre_gain_r);
    end
    for (int k = 1; k < STG_OUT; k++) begin
      if (stg_en[k]) x_r[k] <= x_r[k-1];
    end
    if (stg_en[STG_GAIN]) g_r[STG_GAIN] <= sat16(34'(prod_r >>> 15));
    for (int k = STG_GAIN + 1; k <= STG_DIVQ; k++) begin
      if (stg_en[k]) g_r[k] <= g_r[k-1];
    end
    if (stg_en[STG_SQ]) sq_hi_r <= gain_sq[30:15];
    if (stg_en[STG_SG]) sg_r    <= sg_full[31:0];
    if (stg_en[STG_QQ]) begin
      qq_r  <= 32'(sg_mag[30:15]) * 32'(RECIP3);
      neg_r <= sg_neg;
    end
    if (stg_en[STG_WS]) ws_r[STG_WS] <= soft_wet;
    for (int k = STG_WS + 1; k <= STG_DIVQ; k++) begin
      if (stg_en[k]) ws_r[k] <= ws_r[k-1];
    end
    if (stg_en[STG_WET]) wet_r <= wet_sel;
    if (stg_en[STG_MIX]) begin
      wm_r <= wm_full;
      dm_r <= dm_full;
    end
    if (stg_en[STG_OUT]) out_r <= enable_r ? mixed : x_r[STG_MIX];
  end

  assign out_sample_out = out_r;

endmodule

// ----- design/adist_div.sv -----
module adist_div (
  input  logic                            clk,
  input  logic [adist_pkg::DIV_STG-1:0]   stg_en,
  input  logic [adist_pkg::SAMP_W-1:0]    mag_in,
  output logic [adist_pkg::DIV_Q_W-1:0]   quo_out
);
  import adist_pkg::*;

  // Restoring divide of (mag << 15) by (32768 + mag); the quotient always fits 15 bits,
  // so the partial remainder starts at mag and only zeros are shifted in.
  logic [DIV_D_W-1:0] rem_r [0:DIV_STG-1];
  logic [DIV_D_W-1:0] den_r [0:DIV_STG-1];
  logic [DIV_Q_W-1:0] quo_r [0:DIV_STG-1];

  logic [DIV_D_W-1:0] rem_nxt [1:DIV_STG-1];
  logic [DIV_Q_W-1:0] quo_nxt [1:DIV_STG-1];

  // Three quotient bits per stage
  always_comb begin
    logic [DIV_D_W-1:0] rem;
    logic [DIV_D_W:0]   trial;
    logic [DIV_Q_W-1:0] quo;
    for (int j = 1; j < DIV_STG; j++) begin
      rem = rem_r[j-1];
      quo = quo_r[j-1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {rem, 1'b0};
        if (trial >= {1'b0, den_r[j-1]}) begin
          trial = trial - {1'b0, den_r[j-1]};
          quo   = {quo[DIV_Q_W-2:0], 1'b1};
        end else begin
          quo   = {quo[DIV_Q_W-2:0], 1'b0};
        end
        rem = trial[DIV_D_W-1:0];
      end
      rem_nxt[j] = rem;
      quo_nxt[j] = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      rem_r[0] <= {1'b0, mag_in};
      den_r[0] <= Q15_ONE + {1'b0, mag_in};
      quo_r[0] <= '0;
    end
    for (int j = 1; j < DIV_STG; j++) begin
      if (stg_en[j]) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_r[j-1];
        quo_r[j] <= quo_nxt[j];
      end
    end
  end

  assign quo_out = quo_r[DIV_STG-1];

endmodule

// ----- bench/tb_audio_distortion_q15.sv -----
module tb_audio_distortion_q15;
  import adist_pkg::*;

  localparam int     LATENCY    = 10;
  localparam longint SOFT_DIV   = 98304;
  localparam longint UNITY_GAIN = 32768;
  localparam int     MAX_REPORT = 10;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic signed [SAMP_W-1:0]    in_sample_in   = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic signed [SAMP_W-1:0]    out_sample_out;
  logic                        cfg_valid      = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index      = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata      = '0;

  // Shadow copy of the registers, starting from reset values
  logic                        shadow_enable  = 1'b0;
  mode_t                       shadow_mode    = MODE_WAVE;
  logic signed [SAMP_W-1:0]    shadow_gain    = 16'sd32767;
  logic [MIX_W-1:0]            shadow_mix     = 15'd16384;

  logic signed [SAMP_W-1:0]    expected_samples[$];
  int                          error_count    = 0;
  bit                          tx_idle_en     = 1'b0;
  bit                          rx_stall_en    = 1'b0;
  int                          long_hold      = 0;

  audio_distortion_q15 i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_q15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Expected output for one sample under the current shadow registers
  function automatic logic signed [SAMP_W-1:0] distort_sample(input logic signed [SAMP_W-1:0] x);
    longint xs;
    longint g;
    longint sq;
    longint mag;
    longint wet;
    longint mix;
    longint wet_part;
    longint dry_part;
    longint y;
    xs = longint'(x);
    if (!shadow_enable) return x;
    g = clamp_q15((xs * longint'(shadow_gain)) >>> 15);
    case (shadow_mode)
      MODE_SOFT: begin
        sq  = (g * g) >>> 15;
        wet = g - (sq * g) / SOFT_DIV;
      end
      MODE_HARD: wet = g;
      MODE_WAVE: begin
        mag = (g < 0) ? -g : g;
        wet = (g * UNITY_GAIN) / (UNITY_GAIN + mag);
      end
      default: wet = xs;
    endcase
    mix      = longint'(shadow_mix);
    wet_part = clamp_q15((wet * mix) >>> 15);
    dry_part = clamp_q15((xs * (UNITY_GAIN - mix)) >>> 15);
    y        = clamp_q15(wet_part + dry_part);
    return y[SAMP_W-1:0];
  endfunction

  // Mostly full-range values, with the rails and small magnitudes mixed in
  function automatic logic signed [SAMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return SAMP_W'($urandom_range(0, 511)) - 16'sd256;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  // Record an expectation for every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_samples.push_back(distort_sample(in_sample_in));
    end
  end

  // Compare every accepted output word with the oldest expectation
  always @(posedge clk) begin
    logic signed [SAMP_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORT) begin
          $display("ERROR: unexpected output word %0d", out_sample_out);
        end
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_out !== want) begin
          error_count++;
          if (error_count <= MAX_REPORT) begin
            $display("ERROR: sample_out expected %0d (0x%h) got %0d (0x%h)",
                     want, want, out_sample_out, out_sample_out);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Send one sample; returns right after the edge that takes it
  task automatic send_sample(input logic signed [SAMP_W-1:0] s);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // Wait until every expected word is out, then let the pipe settle
  task automatic wait_idle();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLE:   shadow_enable = data[0];
      REG_MODE:     shadow_mode   = mode_t'(data[1:0]);
      REG_PRE_GAIN: shadow_gain   = data;
      REG_WET_MIX:  shadow_mix    = data[MIX_W-1:0];
      default:      ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Disabled after reset: samples pass through whatever the other registers hold
  task automatic test_passthrough();
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    end_burst();
    wait_idle();
  endtask

  // Each shaper at reset gain and mix; upper data bits set to check masking
  task automatic test_shapers();
    mode_t m;
    write_reg(REG_ENABLE, 16'hffff);
    for (int i = 0; i < 4; i++) begin
      m = mode_t'(i);
      write_reg(REG_MODE, {14'h3fff, m});
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh5555);
      end_burst();
      wait_idle();
    end
  endtask

  // Full negative gain with full wet mix, then zero wet mix (dry path at unity)
  task automatic test_corner_registers();
    write_reg(REG_MODE, {14'h0, MODE_HARD});
    write_reg(REG_PRE_GAIN, 16'h8000);
    write_reg(REG_WET_MIX, 16'hffff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    end_burst();
    wait_idle();
    write_reg(REG_WET_MIX, 16'h8000);
    send_sample(16'sh8000);
    send_sample(16'shaaaa);
    end_burst();
    wait_idle();
  endtask

  // Several random settings, extremes included, each with a burst of samples
  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] data;
    for (int phase = 0; phase < 10; phase++) begin
      tx_idle_en  = (phase % 3 != 2);
      rx_stall_en = (phase % 3 != 2);
      data    = CFG_DATA_W'($urandom);
      data[0] = ($urandom_range(0, 4) != 0);
      write_reg(REG_ENABLE, data);
      data      = CFG_DATA_W'($urandom);
      data[1:0] = 2'(phase % 4);
      write_reg(REG_MODE, data);
      case ($urandom_range(0, 5))
        0:       data = 16'h8000;
        1:       data = 16'h7fff;
        2:       data = 16'h0000;
        3:       data = 16'hffff;
        default: data = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_PRE_GAIN, data);
      data = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 4))
        0:       data[MIX_W-1:0] = '0;
        1:       data[MIX_W-1:0] = '1;
        2:       data[MIX_W-1:0] = 15'd1;
        default: ;
      endcase
      write_reg(REG_WET_MIX, data);
      repeat (100) send_sample(pick_sample());
      end_burst();
      wait_idle();
    end
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    write_reg(REG_ENABLE, 16'h0001);
    write_reg(REG_MODE, {14'h0, MODE_SOFT});
    long_hold = 80;
    repeat (40) send_sample(pick_sample());
    end_burst();
    wait_idle();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_stream();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    write_reg(REG_MODE, {14'h0, MODE_WAVE});
    write_reg(REG_PRE_GAIN, CFG_DATA_W'($urandom));
    write_reg(REG_WET_MIX, CFG_DATA_W'($urandom));
    repeat (150) send_sample(pick_sample());
    end_burst();
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_shapers();
    test_corner_registers();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
